FILE: hdl/tgad_pkg.sv
// Shared types, status codes and header constants for the TGA truecolor stream decoder.
package tgad_pkg;

    // One input transaction: a file byte or a restart marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    // One result transaction: a pixel or a header error.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] column;
        logic [15:0] display_row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_pixel;
    } t_out_item;

    // Input kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_PIXEL      = 3'd0;
    localparam logic [2:0] ST_COLOR_MAP  = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd2;
    localparam logic [2:0] ST_ZERO_DIM   = 3'd3;
    localparam logic [2:0] ST_BAD_DEPTH  = 3'd4;

    // Header layout (byte offsets)
    localparam logic [4:0] HDR_LEN       = 5'd18;
    localparam logic [4:0] HB_ID_LEN     = 5'd0;
    localparam logic [4:0] HB_CMAP_TYPE  = 5'd1;
    localparam logic [4:0] HB_IMG_TYPE   = 5'd2;
    localparam logic [4:0] HB_WIDTH_LO   = 5'd12;
    localparam logic [4:0] HB_WIDTH_HI   = 5'd13;
    localparam logic [4:0] HB_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] HB_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] HB_DEPTH      = 5'd16;
    localparam logic [4:0] HB_DESCRIPTOR = 5'd17;

    localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] DEPTH_24           = 8'd24;
    localparam logic [7:0] DEPTH_32           = 8'd32;
    localparam int         TOP_ORIGIN_BIT     = 5;
    localparam logic [7:0] ALPHA_OPAQUE       = 8'hFF;

    // Byte position inside one pixel (B, G, R, A)
    localparam logic [1:0] PB_BLUE  = 2'd0;
    localparam logic [1:0] PB_GREEN = 2'd1;
    localparam logic [1:0] PB_RED   = 2'd2;
    localparam logic [1:0] PB_ALPHA = 2'd3;

endpackage

FILE: hdl/tgad_in_reg.sv
// Input register stage: holds one accepted transaction until the decoder takes it.
module tgad_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tgad_pkg::t_in_item i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output tgad_pkg::t_in_item o_item
);
    import tgad_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_accept;

    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hdl/tgad_core.sv
// Decoder state and per-byte logic: header parse and check, ID skip, pixel assembly.
module tgad_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  tgad_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    output tgad_pkg::t_out_item o_res
);
    import tgad_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_IDSKIP,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [4:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [7:0]  r_id_rem,    n_id_rem;
    logic        r_cmap,      n_cmap;
    logic        r_type_ok,   n_type_ok;
    logic [7:0]  r_depth,     n_depth;
    logic [15:0] r_width,     n_width;
    logic [15:0] r_height,    n_height;
    logic        r_top_first, n_top_first;
    logic [15:0] r_col,       n_col;
    logic [15:0] r_row,       n_row;
    logic [1:0]  r_byte_idx,  n_byte_idx;
    logic [7:0]  r_blue,      n_blue;
    logic [7:0]  r_green,     n_green;
    logic [7:0]  r_red,       n_red;

    logic [7:0]  w_b;
    logic [15:0] w_col_end;
    logic [15:0] w_row_end;
    logic        w_row_wrap;
    logic        w_last;
    logic        w_emit;
    logic [2:0]  w_err;

    assign w_b        = i_item.data_byte;
    assign w_col_end  = r_width - 16'd1;
    assign w_row_end  = r_height - 16'd1;
    assign w_row_wrap = (r_col == w_col_end);
    assign w_last     = w_row_wrap && (r_row == w_row_end);

    // first failing header check wins
    always_comb begin
        priority if (r_cmap) begin
            w_err = ST_COLOR_MAP;
        end else if (!r_type_ok) begin
            w_err = ST_BAD_TYPE;
        end else if (r_width == 16'd0 || r_height == 16'd0) begin
            w_err = ST_ZERO_DIM;
        end else if (r_depth != DEPTH_24 && r_depth != DEPTH_32) begin
            w_err = ST_BAD_DEPTH;
        end else begin
            w_err = ST_PIXEL;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_id_rem    = r_id_rem;
        n_cmap      = r_cmap;
        n_type_ok   = r_type_ok;
        n_depth     = r_depth;
        n_width     = r_width;
        n_height    = r_height;
        n_top_first = r_top_first;
        n_col       = r_col;
        n_row       = r_row;
        n_byte_idx  = r_byte_idx;
        n_blue      = r_blue;
        n_green     = r_green;
        n_red       = r_red;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_emit      = 1'b0;

        if (i_item.kind == KIND_RESTART) begin
            n_phase     = PH_HEADER;
            n_hdr_cnt   = '0;
            n_id_rem    = '0;
            n_cmap      = 1'b0;
            n_type_ok   = 1'b0;
            n_depth     = '0;
            n_width     = '0;
            n_height    = '0;
            n_top_first = 1'b0;
            n_col       = '0;
            n_row       = '0;
            n_byte_idx  = PB_BLUE;
            n_blue      = '0;
            n_green     = '0;
            n_red       = '0;
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    unique case (r_hdr_cnt)
                        HB_ID_LEN:     n_id_rem    = w_b;
                        HB_CMAP_TYPE:  n_cmap      = (w_b != 8'd0);
                        HB_IMG_TYPE:   n_type_ok   = (w_b == IMG_TYPE_TRUECOLOR);
                        HB_WIDTH_LO:   n_width     = {r_width[15:8], w_b};
                        HB_WIDTH_HI:   n_width     = {w_b, r_width[7:0]};
                        HB_HEIGHT_LO:  n_height    = {r_height[15:8], w_b};
                        HB_HEIGHT_HI:  n_height    = {w_b, r_height[7:0]};
                        HB_DEPTH:      n_depth     = w_b;
                        HB_DESCRIPTOR: n_top_first = w_b[TOP_ORIGIN_BIT];
                        default: ;
                    endcase
                    n_hdr_cnt = r_hdr_cnt + 5'd1;
                    // all checked fields are in before the descriptor byte
                    if (r_hdr_cnt == HDR_LEN - 5'd1) begin
                        if (w_err != ST_PIXEL) begin
                            n_phase      = PH_DONE;
                            o_res_valid  = 1'b1;
                            o_res.status = w_err;
                        end else if (r_id_rem != 8'd0) begin
                            n_phase = PH_IDSKIP;
                        end else begin
                            n_phase = PH_PIXELS;
                        end
                    end
                end
                PH_IDSKIP: begin
                    n_id_rem = r_id_rem - 8'd1;
                    if (r_id_rem == 8'd1) begin
                        n_phase = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    unique case (r_byte_idx)
                        PB_BLUE: begin
                            n_blue     = w_b;
                            n_byte_idx = PB_GREEN;
                        end
                        PB_GREEN: begin
                            n_green    = w_b;
                            n_byte_idx = PB_RED;
                        end
                        PB_RED: begin
                            n_red = w_b;
                            if (r_depth == DEPTH_32) begin
                                n_byte_idx = PB_ALPHA;
                            end else begin
                                w_emit = 1'b1;
                            end
                        end
                        PB_ALPHA: begin
                            w_emit = 1'b1;
                        end
                        default: ;
                    endcase
                    if (w_emit) begin
                        n_byte_idx        = PB_BLUE;
                        o_res_valid       = 1'b1;
                        o_res.status      = ST_PIXEL;
                        o_res.column      = r_col;
                        o_res.display_row = r_top_first ? r_row : (w_row_end - r_row);
                        o_res.red         = (r_byte_idx == PB_ALPHA) ? r_red : w_b;
                        o_res.green       = r_green;
                        o_res.blue        = r_blue;
                        o_res.alpha       = (r_byte_idx == PB_ALPHA) ? w_b : ALPHA_OPAQUE;
                        o_res.last_pixel  = w_last;
                        if (w_last) begin
                            n_phase = PH_DONE;
                        end else if (w_row_wrap) begin
                            n_col = '0;
                            n_row = r_row + 16'd1;
                        end else begin
                            n_col = r_col + 16'd1;
                        end
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_id_rem    <= '0;
            r_cmap      <= 1'b0;
            r_type_ok   <= 1'b0;
            r_depth     <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_top_first <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_byte_idx  <= PB_BLUE;
            r_blue      <= '0;
            r_green     <= '0;
            r_red       <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_id_rem    <= n_id_rem;
            r_cmap      <= n_cmap;
            r_type_ok   <= n_type_ok;
            r_depth     <= n_depth;
            r_width     <= n_width;
            r_height    <= n_height;
            r_top_first <= n_top_first;
            r_col       <= n_col;
            r_row       <= n_row;
            r_byte_idx  <= n_byte_idx;
            r_blue      <= n_blue;
            r_green     <= n_green;
            r_red       <= n_red;
        end
    end

endmodule

FILE: hdl/tgad_out_reg.sv
// Result register: holds one result transaction until the downstream side takes it.
module tgad_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tgad_pkg::t_out_item  i_res,
    output logic                o_valid,
    input  logic                i_stall,
    output tgad_pkg::t_out_item  o_result,
    output logic                o_free
);
    import tgad_pkg::*;

    logic      r_valid;
    t_out_item r_result;

    // room next cycle if empty or being drained now
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: hdl/tga_truecolor_stream_decoder.sv
// Top level of the TGA truecolor stream decoder.
//
// Decodes an uncompressed truecolor TGA file (image type 2) delivered one byte
// per input transaction. The 18-byte header is collected and checked; the first
// failure is reported as one error result (color-mapped, type not 2, zero width
// or height, depth not 24 or 32), after which data bytes are dropped until a
// restart transaction (kind = 1) arrives. A good header is followed by skipping
// the ID field, then B,G,R(,A) bytes are assembled into pixels, each given out
// as RGBA with its column and display row. The row is flipped (height-1-row)
// unless descriptor bit 5 (top origin) is set; alpha reads 255 at 24 bpp. After
// the last pixel (flagged by last_pixel) bytes are again dropped until restart.
// A short file simply leaves the decoder waiting; nothing is reported.
// Rate: one input transaction per clock, sustained, as long as results are
// taken. From input acceptance, the transaction sits in the input register
// while the decoder logic works on it, and the result register loads when the
// transaction moves on once that register has room; the result is offered
// downstream from then on. The input register and the result register together
// give two slots, so a new transaction is still taken while a finished result
// waits under downstream stall; o_in_stall rises only when both slots are held.
// Restart and most data bytes produce no result; a pixel result comes on the
// final byte of each pixel, an error result on the last header byte.
module tga_truecolor_stream_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tgad_pkg::t_in_item   i_item,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tgad_pkg::t_out_item  o_result
);
    import tgad_pkg::*;

    logic      w_stage_valid;
    t_in_item  w_stage_item;
    logic      w_out_free;
    logic      w_fire;
    logic      w_res_valid;
    t_out_item w_res;

    // the held transaction moves on whenever the result register has room
    assign w_fire = w_stage_valid && w_out_free;

    tgad_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (i_item),
        .i_advance (w_out_free),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    tgad_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (w_stage_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    tgad_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && w_res_valid),
        .i_res    (w_res),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (o_result),
        .o_free   (w_out_free)
    );

endmodule

FILE: hdl/tgad_checker.sv
// Port-level checker for the TGA truecolor stream decoder, bound to the top level.
module tgad_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tgad_pkg::t_out_item  o_result
);
    import tgad_pkg::*;

    // stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result))
        else $error("result changed under stall");

    // error results carry no coordinates or flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.status != ST_PIXEL |->
            o_result.column == 16'd0 && o_result.display_row == 16'd0 &&
            o_result.alpha == 8'd0 && o_result.last_pixel == 1'b0)
        else $error("error result with pixel payload");

    // status stays within the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_result.status <= ST_BAD_DEPTH)
        else $error("undefined status code");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind tga_truecolor_stream_decoder tgad_checker u_tgad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_result    (o_result)
);
